### src/sfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Searchable FIFO queue package
// Shared sizes, request codes and control bundles for the queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

    localparam int DEPTH      = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int OFF_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W      = OFF_W + 1;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic search_done;
    } stat_t;

    function automatic logic [PTR_W-1:0] ring_add(
        input logic [PTR_W-1:0] base,
        input logic [OFF_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] wrapped;
        begin
            sum = SUM_W'(base) + SUM_W'(offset);
            wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
            if (wrapped >= SUM_W'(DEPTH))
            begin
                wrapped = '0;
            end
            return wrapped[PTR_W-1:0];
        end
    endfunction

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] ptr);
        begin
            return (ptr == PTR_W'(DEPTH - 1)) ? '0 : (ptr + PTR_W'(1));
        end
    endfunction

endpackage

### src/sfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Searchable FIFO queue controller
// Sequences each request and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module sfq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    output logic           out_valid,
    input  logic           out_ready,
    input  sfq_pkg::stat_t stat,
    output sfq_pkg::ctrl_t ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_SEARCH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    if (sfq_pkg::req_t'(req_type) == sfq_pkg::REQ_SEARCH)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (stat.search_done)
                begin
                    if (slot_free)
                    begin
                        ctrl.commit = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/sfq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Searchable FIFO queue datapath
// Entry memory, ring pointers, search scan and the result register.
// ----------------------------------------------------------------------------
module sfq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfq_pkg::ctrl_t                      ctrl,
    output sfq_pkg::stat_t                      stat,
    input  logic [1:0]                          req_type,
    input  logic signed [sfq_pkg::DATA_W-1:0]   in_value,
    input  logic [sfq_pkg::POS_W-1:0]           in_position,
    output logic                                status,
    output logic signed [sfq_pkg::DATA_W-1:0]   out_value,
    output logic [sfq_pkg::POS_W-1:0]           out_position,
    output logic [sfq_pkg::COUNT_W-1:0]         count
);

    logic signed [sfq_pkg::DATA_W-1:0] mem [sfq_pkg::DEPTH];

    sfq_pkg::req_t                     req_reg;
    logic signed [sfq_pkg::DATA_W-1:0] value_reg;
    logic [sfq_pkg::POS_W-1:0]         pos_reg;
    logic [sfq_pkg::CNT_W-1:0]         idx_reg;
    logic [sfq_pkg::CNT_W-1:0]         idx_next;
    logic signed [sfq_pkg::DATA_W-1:0] rdata_reg;
    logic [sfq_pkg::PTR_W-1:0]         rd_ptr_reg;
    logic [sfq_pkg::PTR_W-1:0]         rd_ptr_next;
    logic [sfq_pkg::PTR_W-1:0]         wr_ptr_reg;
    logic [sfq_pkg::PTR_W-1:0]         wr_ptr_next;
    logic [sfq_pkg::CNT_W-1:0]         occ_reg;
    logic [sfq_pkg::CNT_W-1:0]         occ_next;

    logic                              status_reg;
    logic                              status_next;
    logic signed [sfq_pkg::DATA_W-1:0] out_value_reg;
    logic signed [sfq_pkg::DATA_W-1:0] out_value_next;
    logic [sfq_pkg::POS_W-1:0]         out_position_reg;
    logic [sfq_pkg::POS_W-1:0]         out_position_next;
    logic [sfq_pkg::COUNT_W-1:0]       count_reg;

    logic                              rd_en;
    logic [sfq_pkg::OFF_W-1:0]         rd_offset;
    logic [sfq_pkg::PTR_W-1:0]         rd_addr;
    logic                              full;
    logic                              empty;
    logic                              peek_bad;
    logic                              search_end;
    logic                              search_hit;
    logic                              mem_we;

    assign full       = (occ_reg == sfq_pkg::CNT_W'(sfq_pkg::DEPTH));
    assign empty      = (occ_reg == '0);
    assign peek_bad   = (sfq_pkg::OFF_W'(pos_reg) >= sfq_pkg::OFF_W'(occ_reg));
    assign search_end = (idx_reg >= occ_reg);
    assign search_hit = (rdata_reg == value_reg);
    assign stat.search_done = search_end || search_hit;

    assign idx_next = idx_reg + sfq_pkg::CNT_W'(1);
    assign rd_en    = ctrl.load || ctrl.step;

    always_comb
    begin
        if (ctrl.load)
        begin
            if (sfq_pkg::req_t'(req_type) == sfq_pkg::REQ_PEEK)
            begin
                rd_offset = sfq_pkg::OFF_W'(in_position);
            end
            else
            begin
                rd_offset = '0;
            end
        end
        else
        begin
            rd_offset = sfq_pkg::OFF_W'(idx_next);
        end
    end

    assign rd_addr = sfq_pkg::ring_add(rd_ptr_reg, rd_offset);
    assign mem_we  = ctrl.commit && (req_reg == sfq_pkg::REQ_PUSH) && !full;

    always_comb
    begin
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        occ_next          = occ_reg;
        status_next       = 1'b0;
        out_value_next    = '0;
        out_position_next = '0;
        unique case (req_reg)
            sfq_pkg::REQ_PUSH:
            begin
                status_next = full;
                if (!full)
                begin
                    wr_ptr_next = sfq_pkg::ring_inc(wr_ptr_reg);
                    occ_next    = occ_reg + sfq_pkg::CNT_W'(1);
                end
            end
            sfq_pkg::REQ_POP:
            begin
                status_next = empty;
                if (!empty)
                begin
                    out_value_next = rdata_reg;
                    rd_ptr_next    = sfq_pkg::ring_inc(rd_ptr_reg);
                    occ_next       = occ_reg - sfq_pkg::CNT_W'(1);
                end
            end
            sfq_pkg::REQ_PEEK:
            begin
                status_next = peek_bad;
                if (!peek_bad)
                begin
                    out_value_next = rdata_reg;
                end
            end
            sfq_pkg::REQ_SEARCH:
            begin
                status_next = search_end;
                if (!search_end)
                begin
                    out_position_next = sfq_pkg::POS_W'(idx_reg);
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= value_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_reg   <= sfq_pkg::req_t'(req_type);
            value_reg <= in_value;
            pos_reg   <= in_position;
            idx_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            idx_reg <= idx_next;
        end
        if (ctrl.commit)
        begin
            status_reg       <= status_next;
            out_value_reg    <= out_value_next;
            out_position_reg <= out_position_next;
            count_reg        <= sfq_pkg::COUNT_W'(occ_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else if (ctrl.commit)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_position_reg;
    assign count        = count_reg;

endmodule

### src/searchable_fifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Searchable FIFO queue
// Ring-buffered FIFO of signed words with push, pop, peek and search.
// ----------------------------------------------------------------------------
// The queue takes one request beat at a time and answers each with exactly
// one result beat. Push, pop and peek load the result register as the
// controller leaves its execute state. Search compares one stored entry per
// cycle through the single read port of the entry memory, from the head of
// the queue, and loads the result at the first match or once every stored
// entry has missed. A new request beat is taken in the cycle after the
// previous request has been handed to the result register, even while that
// result still waits for out_ready. A request whose result register is still
// occupied waits in the controller until out_ready frees it.
module searchable_fifo_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic signed [sfq_pkg::DATA_W-1:0]   in_value,
    input  logic [sfq_pkg::POS_W-1:0]           in_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic signed [sfq_pkg::DATA_W-1:0]   out_value,
    output logic [sfq_pkg::POS_W-1:0]           out_position,
    output logic [sfq_pkg::COUNT_W-1:0]         count
);

    sfq_pkg::ctrl_t ctrl;
    sfq_pkg::stat_t stat;

    sfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    sfq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .req_type     (req_type),
        .in_value     (in_value),
        .in_position  (in_position),
        .status       (status),
        .out_value    (out_value),
        .out_position (out_position),
        .count        (count)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("Queue accepted a request beat while busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> (!out_valid || out_ready))
    else $error("Result register overwritten before its beat was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= sfq_pkg::COUNT_W'(sfq_pkg::DEPTH)))
    else $error("Reported count exceeds the queue depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load || ctrl.step) |-> !ctrl.commit)
    else $error("Request loaded or stepped in the same cycle as a commit.");
`endif

endmodule

### sim/searchable_fifo_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Searchable FIFO queue testbench
// Sends push, pop, peek and search requests into the queue. A directed
// opening covers the empty and full edges and the extreme values. A long
// random part follows, with phases that lean toward filling or draining.
// A shadow ring predicts every result, and each result beat is checked
// field by field. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module searchable_fifo_queue_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int IDLE_PERCENT   = 13;
    localparam int QUIET_FIRST    = 3000;
    localparam int QUIET_LAST     = 5000;

    typedef struct {
        sfq_pkg::req_t                      kind;
        logic signed [sfq_pkg::DATA_W-1:0]  value;
        logic [sfq_pkg::POS_W-1:0]          position;
    } queue_request_t;

    typedef struct {
        logic                               status;
        logic signed [sfq_pkg::DATA_W-1:0]  value;
        logic [sfq_pkg::POS_W-1:0]          position;
        logic [sfq_pkg::COUNT_W-1:0]        count;
    } queue_answer_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [1:0]                          req_type = sfq_pkg::REQ_PUSH;
    logic signed [sfq_pkg::DATA_W-1:0]   in_value = '0;
    logic [sfq_pkg::POS_W-1:0]           in_position = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                status;
    logic signed [sfq_pkg::DATA_W-1:0]   out_value;
    logic [sfq_pkg::POS_W-1:0]           out_position;
    logic [sfq_pkg::COUNT_W-1:0]         count;

    queue_request_t                      pending_requests[$];
    queue_answer_t                       expected_answers[$];

    logic signed [sfq_pkg::DATA_W-1:0]   ring_words[sfq_pkg::DEPTH];
    int                                  ring_head = 0;
    int                                  ring_tail = 0;
    int                                  ring_fill = 0;

    int                                  error_count = 0;
    int                                  cycle_no = 0;
    int                                  stall_cycles = 0;
    int                                  answers_checked = 0;
    int                                  failure_answers = 0;
    int                                  kind_count[4] = '{0, 0, 0, 0};

    logic signed [sfq_pkg::DATA_W-1:0]   value_pool[8] = '{
        32'sh0, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
        32'sd5, 32'sd17, -32'sd42, 32'h5555_aaaa
    };
    int                                  plan_fill = 0;

    searchable_fifo_queue DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .in_value(in_value),
        .in_position(in_position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .out_value(out_value),
        .out_position(out_position),
        .count(count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        begin
            $display("[%0t] MISMATCH: %s", $time, msg);
            error_count++;
        end
    endtask

    function automatic queue_answer_t predict_answer(
        input sfq_pkg::req_t                     kind,
        input logic signed [sfq_pkg::DATA_W-1:0] value,
        input logic [sfq_pkg::POS_W-1:0]         position
    );
        queue_answer_t ans;
        int            k;
        begin
            ans.status = 1'b0;
            ans.value = '0;
            ans.position = '0;
            case (kind)
                sfq_pkg::REQ_PUSH:
                begin
                    if (ring_fill >= sfq_pkg::DEPTH)
                    begin
                        ans.status = 1'b1;
                    end
                    else
                    begin
                        ring_words[ring_tail] = value;
                        ring_tail = (ring_tail + 1) % sfq_pkg::DEPTH;
                        ring_fill++;
                    end
                end
                sfq_pkg::REQ_POP:
                begin
                    if (ring_fill == 0)
                    begin
                        ans.status = 1'b1;
                    end
                    else
                    begin
                        ans.value = ring_words[ring_head];
                        ring_head = (ring_head + 1) % sfq_pkg::DEPTH;
                        ring_fill--;
                    end
                end
                sfq_pkg::REQ_PEEK:
                begin
                    if (int'(position) >= ring_fill)
                    begin
                        ans.status = 1'b1;
                    end
                    else
                    begin
                        ans.value = ring_words[(ring_head + int'(position)) % sfq_pkg::DEPTH];
                    end
                end
                default:
                begin
                    ans.status = 1'b1;
                    for (k = ring_fill - 1; k >= 0; k--)
                    begin
                        if (ring_words[(ring_head + k) % sfq_pkg::DEPTH] == value)
                        begin
                            ans.status = 1'b0;
                            ans.position = sfq_pkg::POS_W'(k);
                        end
                    end
                end
            endcase
            ans.count = sfq_pkg::COUNT_W'(ring_fill);
            return ans;
        end
    endfunction

    task automatic add_request(
        input sfq_pkg::req_t                     kind,
        input logic signed [sfq_pkg::DATA_W-1:0] value,
        input logic [sfq_pkg::POS_W-1:0]         position
    );
        queue_request_t req;
        begin
            req.kind = kind;
            req.value = value;
            req.position = position;
            pending_requests.push_back(req);
            if (kind == sfq_pkg::REQ_PUSH && plan_fill < sfq_pkg::DEPTH)
            begin
                plan_fill++;
            end
            if (kind == sfq_pkg::REQ_POP && plan_fill > 0)
            begin
                plan_fill--;
            end
        end
    endtask

    function automatic logic signed [sfq_pkg::DATA_W-1:0] pick_value(input int pool_percent);
        begin
            if ($urandom_range(99) < pool_percent)
            begin
                return value_pool[$urandom_range(7)];
            end
            return $urandom;
        end
    endfunction

    // The driver holds a beat steady until it is taken, then loads the next one.
    always @(posedge clk)
    begin : request_driver
        logic           quiet;
        queue_request_t req;
        quiet = (cycle_no >= QUIET_FIRST && cycle_no < QUIET_LAST);
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    req_type <= req.kind;
                    in_value <= req.value;
                    in_position <= req.position;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : answer_monitor
        queue_answer_t want;
        if (rst_n)
        begin
            cycle_no <= cycle_no + 1;
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_error("result beat with no request outstanding");
                end
                else
                begin
                    want = expected_answers.pop_front();
                    answers_checked++;
                    if (status !== want.status)
                    begin
                        report_error($sformatf("status got %0b expected %0b",
                                               status, want.status));
                    end
                    if (out_value !== want.value)
                    begin
                        report_error($sformatf("out_value got %0d expected %0d",
                                               out_value, want.value));
                    end
                    if (out_position !== want.position)
                    begin
                        report_error($sformatf("out_position got %0d expected %0d",
                                               out_position, want.position));
                    end
                    if (count !== want.count)
                    begin
                        report_error($sformatf("count got %0d expected %0d",
                                               count, want.count));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_answer(sfq_pkg::req_t'(req_type), in_value, in_position);
                expected_answers.push_back(want);
                kind_count[req_type]++;
                if (want.status)
                begin
                    failure_answers++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d cycles without a beat", WATCHDOG_LIMIT);
                $display("searchable_fifo_queue verification failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int            n;
        int            mode;
        int            roll;
        sfq_pkg::req_t kind;

        // Directed opening: empty edges, fill to full with extreme values,
        // full edges, then hits, a duplicate, a miss and a pop.
        add_request(sfq_pkg::REQ_POP, 32'sd0, 4'd0);
        add_request(sfq_pkg::REQ_PEEK, 32'sd0, 4'd0);
        add_request(sfq_pkg::REQ_SEARCH, 32'sd0, 4'd0);
        for (n = 0; n < sfq_pkg::DEPTH; n++)
        begin
            add_request(sfq_pkg::REQ_PUSH,
                        value_pool[n % 8] ^ (n >= 8 ? 32'sh0 : 32'sh0), 4'd0);
        end
        add_request(sfq_pkg::REQ_PUSH, 32'sh1234_5678, 4'd15);
        add_request(sfq_pkg::REQ_PEEK, 32'sd0, 4'd15);
        add_request(sfq_pkg::REQ_PEEK, 32'sd0, 4'd0);
        add_request(sfq_pkg::REQ_SEARCH, 32'sh8000_0000, 4'd0);
        add_request(sfq_pkg::REQ_SEARCH, 32'sh5555_aaaa, 4'd0);
        add_request(sfq_pkg::REQ_SEARCH, 32'sh1234_5678, 4'd0);
        add_request(sfq_pkg::REQ_POP, 32'sd0, 4'd0);

        // Random part: phases lean toward filling, draining or balance.
        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
            begin
                mode = $urandom_range(2);
            end
            roll = $urandom_range(99);
            case (mode)
                0:
                begin
                    kind = (roll < 45) ? sfq_pkg::REQ_PUSH :
                           (roll < 55) ? sfq_pkg::REQ_POP :
                           (roll < 75) ? sfq_pkg::REQ_PEEK : sfq_pkg::REQ_SEARCH;
                end
                1:
                begin
                    kind = (roll < 10) ? sfq_pkg::REQ_PUSH :
                           (roll < 50) ? sfq_pkg::REQ_POP :
                           (roll < 75) ? sfq_pkg::REQ_PEEK : sfq_pkg::REQ_SEARCH;
                end
                default:
                begin
                    kind = (roll < 30) ? sfq_pkg::REQ_PUSH :
                           (roll < 55) ? sfq_pkg::REQ_POP :
                           (roll < 75) ? sfq_pkg::REQ_PEEK : sfq_pkg::REQ_SEARCH;
                end
            endcase
            case (kind)
                sfq_pkg::REQ_PUSH:   add_request(kind, pick_value(50), 4'($urandom));
                sfq_pkg::REQ_SEARCH: add_request(kind, pick_value(70), 4'($urandom));
                sfq_pkg::REQ_PEEK:
                begin
                    if (plan_fill > 0 && $urandom_range(99) < 75)
                    begin
                        add_request(kind, $urandom, 4'($urandom_range(plan_fill - 1)));
                    end
                    else
                    begin
                        add_request(kind, $urandom, 4'($urandom_range(15)));
                    end
                end
                default:             add_request(kind, $urandom, 4'($urandom));
            endcase
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (expected_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (sfq_pkg::DEPTH + 8) @(negedge clk);

        $display("Checked %0d results: %0d push, %0d pop, %0d peek, %0d search requests.",
                 answers_checked, kind_count[sfq_pkg::REQ_PUSH],
                 kind_count[sfq_pkg::REQ_POP], kind_count[sfq_pkg::REQ_PEEK],
                 kind_count[sfq_pkg::REQ_SEARCH]);
        $display("%0d of those reported failure; %0d field mismatches were seen.",
                 failure_answers, error_count);
        if (error_count == 0)
        begin
            $display("searchable_fifo_queue verification clean");
        end
        else
        begin
            $display("searchable_fifo_queue verification failed");
        end
        $finish;
    end

endmodule
